### hdl/exp_th_pkg.sv
package exp_th_pkg;

  // Series and lane geometry
  localparam int MAX_TERMS = 64;
  localparam int LANES     = 4;
  localparam int TERM_W    = 7;
  localparam int K_IDX_W   = $clog2(MAX_TERMS);

  // Field widths
  localparam int X_W   = 21;
  localparam int XM_W  = 21;   // |x| reaches 2^20
  localparam int OUT_W = 48;

  // Datapath widths
  localparam int R_W     = 64;   // signed Q.32 accumulator
  localparam int RECIP_W = 33;   // 1/k in Q.32, k=1 needs bit 32
  localparam int P_W     = 37;   // |x|/k in Q.32
  localparam int MUL_W   = 32;
  localparam int ACC_W   = 96;

  localparam logic [R_W-1:0] Q32_ONE = 64'h0000_0001_0000_0000;
  localparam logic [R_W-1:0] RND_HALF = 64'd128;

  localparam logic [TERM_W-1:0] TERM_MIN   = 7'd2;
  localparam logic [TERM_W-1:0] TERM_MAX   = TERM_W'(MAX_TERMS);
  localparam logic [TERM_W-1:0] TERM_RESET = TERM_W'(MAX_TERMS);

  // Entry i holds round(2^32 / (i+1))
  localparam logic [RECIP_W-1:0] RECIP_ROM [MAX_TERMS] = '{
    RECIP_W'((Q32_ONE + 64'd0) / 64'd1),
    RECIP_W'((Q32_ONE + 64'd1) / 64'd2),
    RECIP_W'((Q32_ONE + 64'd1) / 64'd3),
    RECIP_W'((Q32_ONE + 64'd2) / 64'd4),
    RECIP_W'((Q32_ONE + 64'd2) / 64'd5),
    RECIP_W'((Q32_ONE + 64'd3) / 64'd6),
    RECIP_W'((Q32_ONE + 64'd3) / 64'd7),
    RECIP_W'((Q32_ONE + 64'd4) / 64'd8),
    RECIP_W'((Q32_ONE + 64'd4) / 64'd9),
    RECIP_W'((Q32_ONE + 64'd5) / 64'd10),
    RECIP_W'((Q32_ONE + 64'd5) / 64'd11),
    RECIP_W'((Q32_ONE + 64'd6) / 64'd12),
    RECIP_W'((Q32_ONE + 64'd6) / 64'd13),
    RECIP_W'((Q32_ONE + 64'd7) / 64'd14),
    RECIP_W'((Q32_ONE + 64'd7) / 64'd15),
    RECIP_W'((Q32_ONE + 64'd8) / 64'd16),
    RECIP_W'((Q32_ONE + 64'd8) / 64'd17),
    RECIP_W'((Q32_ONE + 64'd9) / 64'd18),
    RECIP_W'((Q32_ONE + 64'd9) / 64'd19),
    RECIP_W'((Q32_ONE + 64'd10) / 64'd20),
    RECIP_W'((Q32_ONE + 64'd10) / 64'd21),
    RECIP_W'((Q32_ONE + 64'd11) / 64'd22),
    RECIP_W'((Q32_ONE + 64'd11) / 64'd23),
    RECIP_W'((Q32_ONE + 64'd12) / 64'd24),
    RECIP_W'((Q32_ONE + 64'd12) / 64'd25),
    RECIP_W'((Q32_ONE + 64'd13) / 64'd26),
    RECIP_W'((Q32_ONE + 64'd13) / 64'd27),
    RECIP_W'((Q32_ONE + 64'd14) / 64'd28),
    RECIP_W'((Q32_ONE + 64'd14) / 64'd29),
    RECIP_W'((Q32_ONE + 64'd15) / 64'd30),
    RECIP_W'((Q32_ONE + 64'd15) / 64'd31),
    RECIP_W'((Q32_ONE + 64'd16) / 64'd32),
    RECIP_W'((Q32_ONE + 64'd16) / 64'd33),
    RECIP_W'((Q32_ONE + 64'd17) / 64'd34),
    RECIP_W'((Q32_ONE + 64'd17) / 64'd35),
    RECIP_W'((Q32_ONE + 64'd18) / 64'd36),
    RECIP_W'((Q32_ONE + 64'd18) / 64'd37),
    RECIP_W'((Q32_ONE + 64'd19) / 64'd38),
    RECIP_W'((Q32_ONE + 64'd19) / 64'd39),
    RECIP_W'((Q32_ONE + 64'd20) / 64'd40),
    RECIP_W'((Q32_ONE + 64'd20) / 64'd41),
    RECIP_W'((Q32_ONE + 64'd21) / 64'd42),
    RECIP_W'((Q32_ONE + 64'd21) / 64'd43),
    RECIP_W'((Q32_ONE + 64'd22) / 64'd44),
    RECIP_W'((Q32_ONE + 64'd22) / 64'd45),
    RECIP_W'((Q32_ONE + 64'd23) / 64'd46),
    RECIP_W'((Q32_ONE + 64'd23) / 64'd47),
    RECIP_W'((Q32_ONE + 64'd24) / 64'd48),
    RECIP_W'((Q32_ONE + 64'd24) / 64'd49),
    RECIP_W'((Q32_ONE + 64'd25) / 64'd50),
    RECIP_W'((Q32_ONE + 64'd25) / 64'd51),
    RECIP_W'((Q32_ONE + 64'd26) / 64'd52),
    RECIP_W'((Q32_ONE + 64'd26) / 64'd53),
    RECIP_W'((Q32_ONE + 64'd27) / 64'd54),
    RECIP_W'((Q32_ONE + 64'd27) / 64'd55),
    RECIP_W'((Q32_ONE + 64'd28) / 64'd56),
    RECIP_W'((Q32_ONE + 64'd28) / 64'd57),
    RECIP_W'((Q32_ONE + 64'd29) / 64'd58),
    RECIP_W'((Q32_ONE + 64'd29) / 64'd59),
    RECIP_W'((Q32_ONE + 64'd30) / 64'd60),
    RECIP_W'((Q32_ONE + 64'd30) / 64'd61),
    RECIP_W'((Q32_ONE + 64'd31) / 64'd62),
    RECIP_W'((Q32_ONE + 64'd31) / 64'd63),
    RECIP_W'((Q32_ONE + 64'd32) / 64'd64)
  };

  // Steps of one Horner term
  typedef enum logic [2:0] {
    PH_RECIP,   // |x| * 1/k
    PH_PREP,    // latch |x|/k, |r| and sign of r
    PH_MUL0,    // rl * pl
    PH_MUL1,    // rh * pl
    PH_MUL2,    // rl * ph
    PH_MUL3,    // rh * ph
    PH_ACC,     // last partial product
    PH_UPDATE   // r = 1 +/- |r||p| >> 32
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic                 load;
    logic                 step;
    phase_e               phase;
    logic [RECIP_W-1:0]   recip;
  } lane_ctrl_t;

endpackage

### hdl/exp_th_lane.sv
module exp_th_lane (
  input  logic                                  clk_i,
  input  exp_th_pkg::lane_ctrl_t                ctrl_i,
  input  logic signed [exp_th_pkg::X_W-1:0]     x_i,
  output logic        [exp_th_pkg::OUT_W-1:0]   exp_o,
  output logic                                  sat_o
);

  logic                              xneg_q;
  logic [exp_th_pkg::XM_W-1:0]       xmag_q;
  logic [exp_th_pkg::R_W-1:0]        r_q;
  logic [exp_th_pkg::R_W-1:0]        rmag_q;
  logic                              rneg_q;
  logic [exp_th_pkg::P_W-1:0]        pmag_q;
  logic [2*exp_th_pkg::MUL_W-1:0]    prod_q;
  logic [exp_th_pkg::ACC_W-1:0]      acc_q;

  logic [exp_th_pkg::MUL_W-1:0]      mul_a;
  logic [exp_th_pkg::MUL_W-1:0]      mul_b;
  logic [exp_th_pkg::ACC_W-1:0]      addend;
  logic [exp_th_pkg::R_W-1:0]        tmag;
  logic [exp_th_pkg::R_W-1:0]        rnd;

  // shared 32x32 multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.phase)
      exp_th_pkg::PH_RECIP: begin
        mul_a = exp_th_pkg::MUL_W'(xmag_q);
        mul_b = ctrl_i.recip[exp_th_pkg::MUL_W-1:0];
      end
      exp_th_pkg::PH_MUL0: begin
        mul_a = rmag_q[31:0];
        mul_b = pmag_q[31:0];
      end
      exp_th_pkg::PH_MUL1: begin
        mul_a = rmag_q[63:32];
        mul_b = pmag_q[31:0];
      end
      exp_th_pkg::PH_MUL2: begin
        mul_a = rmag_q[31:0];
        mul_b = exp_th_pkg::MUL_W'(pmag_q[36:32]);
      end
      exp_th_pkg::PH_MUL3: begin
        mul_a = rmag_q[63:32];
        mul_b = exp_th_pkg::MUL_W'(pmag_q[36:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // partial product placement, previous cycle's product
  always_comb begin
    case (ctrl_i.phase) inside
      exp_th_pkg::PH_MUL1: addend = exp_th_pkg::ACC_W'(prod_q);
      exp_th_pkg::PH_MUL2,
      exp_th_pkg::PH_MUL3: addend = {exp_th_pkg::ACC_W'(prod_q)} << 32;
      exp_th_pkg::PH_ACC:  addend = {prod_q[31:0], 64'd0};
      default:             addend = '0;
    endcase
  end

  assign tmag = acc_q[95:32];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      prod_q <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      xneg_q <= x_i[exp_th_pkg::X_W-1];
      xmag_q <= x_i[exp_th_pkg::X_W-1] ? (exp_th_pkg::XM_W'(0) - exp_th_pkg::XM_W'(x_i))
                                       : exp_th_pkg::XM_W'(x_i);
      r_q    <= exp_th_pkg::Q32_ONE;
    end else if (ctrl_i.step) begin
      case (ctrl_i.phase) inside
        exp_th_pkg::PH_PREP: begin
          // k = 1 has 1/k = 2^32 exactly
          pmag_q <= ctrl_i.recip[32] ? {xmag_q, 16'd0} : prod_q[52:16];
          rneg_q <= r_q[63];
          rmag_q <= r_q[63] ? (exp_th_pkg::R_W'(0) - r_q) : r_q;
        end
        exp_th_pkg::PH_MUL0: begin
          acc_q <= '0;
        end
        exp_th_pkg::PH_MUL1,
        exp_th_pkg::PH_MUL2,
        exp_th_pkg::PH_MUL3,
        exp_th_pkg::PH_ACC: begin
          acc_q <= acc_q + addend;
        end
        exp_th_pkg::PH_UPDATE: begin
          r_q <= (rneg_q != xneg_q) ? (exp_th_pkg::Q32_ONE - tmag)
                                    : (exp_th_pkg::Q32_ONE + tmag);
        end
        default: begin
        end
      endcase
    end
  end

  // round Q.32 to Q24.24, clamp
  assign rnd   = r_q + exp_th_pkg::RND_HALF;
  assign sat_o = !r_q[63] && (|rnd[63:56]);
  assign exp_o = r_q[63] ? '0 : (sat_o ? '1 : rnd[55:8]);

endmodule

### hdl/exp_th_seq.sv
module exp_th_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [exp_th_pkg::TERM_W-1:0]        term_count_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 out_free_i,
  output logic                                 finish_o,
  output exp_th_pkg::lane_ctrl_t               ctrl_o
);

  exp_th_pkg::seq_state_e            state_q, state_d;
  exp_th_pkg::phase_e                phase_q, phase_d;
  logic [exp_th_pkg::TERM_W-1:0]     k_q, k_d;
  logic [exp_th_pkg::TERM_W-1:0]     n_clamped;

  assign n_clamped = (term_count_i < exp_th_pkg::TERM_MIN) ? exp_th_pkg::TERM_MIN :
                     (term_count_i > exp_th_pkg::TERM_MAX) ? exp_th_pkg::TERM_MAX :
                     term_count_i;

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    k_d     = k_q;
    unique case (state_q)
      exp_th_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = exp_th_pkg::ST_RUN;
          phase_d = exp_th_pkg::PH_RECIP;
          k_d     = n_clamped;
        end
      end
      exp_th_pkg::ST_RUN: begin
        unique case (phase_q)
          exp_th_pkg::PH_RECIP: phase_d = exp_th_pkg::PH_PREP;
          exp_th_pkg::PH_PREP:  phase_d = exp_th_pkg::PH_MUL0;
          exp_th_pkg::PH_MUL0:  phase_d = exp_th_pkg::PH_MUL1;
          exp_th_pkg::PH_MUL1:  phase_d = exp_th_pkg::PH_MUL2;
          exp_th_pkg::PH_MUL2:  phase_d = exp_th_pkg::PH_MUL3;
          exp_th_pkg::PH_MUL3:  phase_d = exp_th_pkg::PH_ACC;
          exp_th_pkg::PH_ACC:   phase_d = exp_th_pkg::PH_UPDATE;
          exp_th_pkg::PH_UPDATE: begin
            phase_d = exp_th_pkg::PH_RECIP;
            if (k_q == exp_th_pkg::TERM_W'(1)) begin
              state_d = exp_th_pkg::ST_DONE;
            end else begin
              k_d = k_q - exp_th_pkg::TERM_W'(1);
            end
          end
          default: phase_d = exp_th_pkg::PH_RECIP;
        endcase
      end
      exp_th_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = exp_th_pkg::ST_IDLE;
        end
      end
      default: state_d = exp_th_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    finish_o      = 1'b0;
    ctrl_o.load   = 1'b0;
    ctrl_o.step   = 1'b0;
    ctrl_o.phase  = phase_q;
    ctrl_o.recip  = exp_th_pkg::RECIP_ROM[exp_th_pkg::K_IDX_W'(k_q - exp_th_pkg::TERM_W'(1))];
    unique case (state_q)
      exp_th_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      exp_th_pkg::ST_RUN: begin
        ctrl_o.step = 1'b1;
      end
      exp_th_pkg::ST_DONE: begin
        finish_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= exp_th_pkg::ST_IDLE;
      phase_q <= exp_th_pkg::PH_RECIP;
      k_q     <= exp_th_pkg::TERM_RESET;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

endmodule

### hdl/exp_taylor_horner_four_lane.sv
// Each accepted item runs N Horner terms, N = term_count clamped to 2..64; the sequencer
// accepts an item only while idle. Each term runs recip, prep, multiply, accumulate and update
// steps on every lane's single shared 32x32 multiplier (one 21x32 and four partial products).
// The result register frees the datapath: the next item is taken while a result waits.
// Reset (rst_ni low, async): sequencer idle, result register empty, term_count = 64.
module exp_taylor_horner_four_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: term_count
  input  logic                                 cfg_we_i,
  input  logic [exp_th_pkg::TERM_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [exp_th_pkg::X_W-1:0]    x_lane0_i,
  input  logic signed [exp_th_pkg::X_W-1:0]    x_lane1_i,
  input  logic signed [exp_th_pkg::X_W-1:0]    x_lane2_i,
  input  logic signed [exp_th_pkg::X_W-1:0]    x_lane3_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [exp_th_pkg::OUT_W-1:0]         exp_lane0_o,
  output logic [exp_th_pkg::OUT_W-1:0]         exp_lane1_o,
  output logic [exp_th_pkg::OUT_W-1:0]         exp_lane2_o,
  output logic [exp_th_pkg::OUT_W-1:0]         exp_lane3_o,
  output logic [exp_th_pkg::LANES-1:0]         saturated_mask_o
);

  logic [exp_th_pkg::TERM_W-1:0]        term_count_q;
  logic                                 out_valid_q;
  logic                                 out_free;
  logic                                 finish;
  exp_th_pkg::lane_ctrl_t               lane_ctrl;

  logic signed [exp_th_pkg::X_W-1:0]    lane_x   [exp_th_pkg::LANES];
  logic [exp_th_pkg::OUT_W-1:0]         lane_exp [exp_th_pkg::LANES];
  logic [exp_th_pkg::LANES-1:0]         lane_sat;
  logic [exp_th_pkg::OUT_W-1:0]         exp_q    [exp_th_pkg::LANES];
  logic [exp_th_pkg::LANES-1:0]         mask_q;

  // config register; must be written only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= exp_th_pkg::TERM_RESET;
    end else if (cfg_we_i) begin
      term_count_q <= cfg_wdata_i;
    end
  end

  assign lane_x[0] = x_lane0_i;
  assign lane_x[1] = x_lane1_i;
  assign lane_x[2] = x_lane2_i;
  assign lane_x[3] = x_lane3_i;

  // result register can take a new item when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  exp_th_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_count_i (term_count_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_free_i   (out_free),
    .finish_o     (finish),
    .ctrl_o       (lane_ctrl)
  );

  // one Horner datapath per lane, all stepped by the same sequencer
  for (genvar l = 0; l < exp_th_pkg::LANES; l++) begin : g_lane
    exp_th_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .x_i    (lane_x[l]),
      .exp_o  (lane_exp[l]),
      .sat_o  (lane_sat[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (finish) begin
      exp_q  <= lane_exp;
      mask_q <= lane_sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign exp_lane0_o      = exp_q[0];
  assign exp_lane1_o      = exp_q[1];
  assign exp_lane2_o      = exp_q[2];
  assign exp_lane3_o      = exp_q[3];
  assign saturated_mask_o = mask_q;

endmodule

### dv/exp_taylor_horner_four_lane_test.sv
`timescale 1ns / 100ps

module exp_taylor_horner_four_lane_test;

  // Stall styles, switched per batch of items
  typedef enum logic [1:0] {
    IDLE_NONE,   // both sides run flat out
    IDLE_SEND,   // sender holds back with probability 71 in 100
    IDLE_RECV,   // receiver stalls with probability 71 in 100
    IDLE_BOTH    // both sides, 21 in 100
  } idle_mode_e;

  typedef logic [exp_th_pkg::LANES-1:0][exp_th_pkg::X_W-1:0] arg_set_t;

  typedef struct packed {
    logic [exp_th_pkg::LANES-1:0][exp_th_pkg::OUT_W-1:0] lane;
    logic [exp_th_pkg::LANES-1:0]                        mask;
  } exp_result_t;

  localparam logic [63:0]    Q32_UNIT       = 64'h0000_0001_0000_0000;
  localparam logic [63:0]    SAT_LEVEL      = (64'd1 << exp_th_pkg::OUT_W) - 64'd1;
  localparam logic [exp_th_pkg::X_W-1:0] X_MIN = 21'h100000;   // -16.0
  localparam logic [exp_th_pkg::X_W-1:0] X_MAX = 21'h0FFFFF;   // 16 - 2^-16
  localparam int             HOLD_CYCLES    = 1500;
  localparam int             WATCHDOG_LIMIT = 8000;
  localparam int             DRAIN_CYCLES   = 8 * exp_th_pkg::MAX_TERMS + 20;
  localparam int             PLAN_LEN       = 12;

  // DUT ports, all inputs known from time zero
  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 cfg_we_i    = 1'b0;
  logic [exp_th_pkg::TERM_W-1:0]        cfg_wdata_i = '0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_ready_o;
  logic signed [exp_th_pkg::X_W-1:0]    x_lane0_i   = '0;
  logic signed [exp_th_pkg::X_W-1:0]    x_lane1_i   = '0;
  logic signed [exp_th_pkg::X_W-1:0]    x_lane2_i   = '0;
  logic signed [exp_th_pkg::X_W-1:0]    x_lane3_i   = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [exp_th_pkg::OUT_W-1:0]         exp_lane0_o;
  logic [exp_th_pkg::OUT_W-1:0]         exp_lane1_o;
  logic [exp_th_pkg::OUT_W-1:0]         exp_lane2_o;
  logic [exp_th_pkg::OUT_W-1:0]         exp_lane3_o;
  logic [exp_th_pkg::LANES-1:0]         saturated_mask_o;

  // Testbench state
  arg_set_t                      arg_q[$];        // items waiting to be offered
  exp_result_t                   exp_due_q[$];    // predicted results, oldest first
  logic [exp_th_pkg::TERM_W-1:0] terms_cfg    = exp_th_pkg::TERM_RESET;   // register shadow
  idle_mode_e                    idle_mode    = IDLE_NONE;
  logic              in_taken     = 1'b0;   // item accepted at the last rising edge
  logic              hold_arm     = 1'b0;   // request for the long receiver hold-off
  logic              hold_used    = 1'b0;
  int                hold_left    = 0;
  int                quiet_cycles = 0;
  int                mismatches   = 0;

  exp_taylor_horner_four_lane u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .x_lane0_i        (x_lane0_i),
    .x_lane1_i        (x_lane1_i),
    .x_lane2_i        (x_lane2_i),
    .x_lane3_i        (x_lane3_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .exp_lane0_o      (exp_lane0_o),
    .exp_lane1_o      (exp_lane1_o),
    .exp_lane2_o      (exp_lane2_o),
    .exp_lane3_o      (exp_lane3_o),
    .saturated_mask_o (saturated_mask_o)
  );

  always #2 clk_i = ~clk_i;

  // One lane of the truncated series, nested form, k = terms down to 1.
  // acc is signed Q.32; each step is acc = 1 +/- (|acc| * |x/k|) >> 32,
  // the product truncated toward zero and the sign taken from both operands.
  function automatic logic [exp_th_pkg::OUT_W-1:0] horner_exp(
      input logic [exp_th_pkg::X_W-1:0] x,
      input int unsigned                terms,
      output logic                      clamped);
    logic [63:0]  xmag, recip, pmag, rmag, tmag, rounded, acc;
    logic [127:0] prod;
    logic         xneg, rneg;
    int unsigned  k;
    xneg = x[exp_th_pkg::X_W-1];
    xmag = xneg ? ((64'd1 << exp_th_pkg::X_W) - 64'(x)) : 64'(x);
    acc  = Q32_UNIT;
    for (k = terms; k >= 1; k--) begin
      // 1/k in Q.32, rounded to nearest
      recip = (Q32_UNIT + 64'(k >> 1)) / 64'(k);
      pmag  = (xmag * recip) >> 16;
      rneg  = acc[63];
      rmag  = rneg ? -acc : acc;
      prod  = 128'(rmag) * 128'(pmag);
      tmag  = prod[95:32];
      acc   = (rneg != xneg) ? (Q32_UNIT - tmag) : (Q32_UNIT + tmag);
    end
    clamped = 1'b0;
    // a truncated series can dip below zero for large negative x: clear to 0
    if (acc[63]) return '0;
    rounded = (acc + 64'd128) >> 8;
    if (rounded > SAT_LEVEL) begin
      clamped = 1'b1;
      return SAT_LEVEL[exp_th_pkg::OUT_W-1:0];
    end
    return rounded[exp_th_pkg::OUT_W-1:0];
  endfunction

  // Expected result of one item under the current term count
  function automatic exp_result_t predict_exp(input arg_set_t args);
    exp_result_t res;
    int unsigned terms;
    logic        clamped;
    // out-of-range term counts are pulled into 2..MAX_TERMS
    terms = terms_cfg;
    if (terms < exp_th_pkg::TERM_MIN) terms = exp_th_pkg::TERM_MIN;
    if (terms > exp_th_pkg::MAX_TERMS) terms = exp_th_pkg::MAX_TERMS;
    for (int i = 0; i < exp_th_pkg::LANES; i++) begin
      res.lane[i] = horner_exp(args[i], terms, clamped);
      res.mask[i] = clamped;
    end
    return res;
  endfunction

  // Random argument, biased toward the interesting regions: small magnitudes,
  // large negatives (series may go negative), large positives, exact extremes.
  function automatic logic [exp_th_pkg::X_W-1:0] pick_arg();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9)) inside
      [0:3]: return r[exp_th_pkg::X_W-1:0];
      [4:5]: return {{(exp_th_pkg::X_W-17){r[16]}}, r[16:0]};
      [6:7]: return {2'b10, r[18:0]};
      8:     return {2'b01, r[18:0]};
      default: begin
        case ($urandom_range(4))
          0:       return X_MIN;
          1:       return X_MAX;
          2:       return '0;
          3:       return '1;
          default: return exp_th_pkg::X_W'(1);
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_item(input logic [exp_th_pkg::X_W-1:0] a0,
                           input logic [exp_th_pkg::X_W-1:0] a1,
                           input logic [exp_th_pkg::X_W-1:0] a2,
                           input logic [exp_th_pkg::X_W-1:0] a3);
    arg_set_t a;
    a[0] = a0;
    a[1] = a1;
    a[2] = a2;
    a[3] = a3;
    arg_q.push_back(a);
  endtask

  // Idle: nothing queued, nothing on the bus, no result outstanding.
  // Every item yields exactly one result, so the datapath is empty too.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (arg_q.size() != 0 || in_valid_i || exp_due_q.size() != 0);
  endtask

  // Register write, only from the idle state; returns just after a rising edge
  task automatic set_terms(input logic [exp_th_pkg::TERM_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    terms_cfg    = value;
    @(posedge clk_i);
  endtask

  // Driver: offers the next pending item on the falling edge. Valid is
  // computed once per edge so it never drops between back-to-back items.
  always @(negedge clk_i) begin : drive
    logic next_valid;
    logic gap;
    arg_set_t a;
    next_valid = in_valid_i && !in_taken;
    case (idle_mode)
      IDLE_SEND: gap = ($urandom_range(99) < 71);
      IDLE_BOTH: gap = ($urandom_range(99) < 21);
      default:   gap = 1'b0;
    endcase
    if (!next_valid && arg_q.size() != 0 && !gap) begin
      a = arg_q.pop_front();
      x_lane0_i  <= a[0];
      x_lane1_i  <= a[1];
      x_lane2_i  <= a[2];
      x_lane3_i  <= a[3];
      next_valid = 1'b1;
    end
    in_valid_i <= next_valid;
  end

  // Receiver: random stalls, plus one long hold-off that fills the block
  // and backs up the input side while the sender keeps offering.
  always @(negedge clk_i) begin : receive
    logic stall;
    stall = 1'b0;
    if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall = 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECV: stall = ($urandom_range(99) < 71);
        IDLE_BOTH: stall = ($urandom_range(99) < 21);
        default:   stall = 1'b0;
      endcase
    end
    out_ready_i <= !stall;
  end

  // Monitor: checks results against the oldest prediction, then predicts
  // for an item accepted on this edge.
  always @(posedge clk_i) begin : monitor
    exp_result_t got, want;
    arg_set_t    a;
    in_taken <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      got.lane[0] = exp_lane0_o;
      got.lane[1] = exp_lane1_o;
      got.lane[2] = exp_lane2_o;
      got.lane[3] = exp_lane3_o;
      got.mask    = saturated_mask_o;
      if (exp_due_q.size() == 0) begin
        report_mismatch("result with none expected", 64'(got.lane[0]), '0);
      end else begin
        want = exp_due_q.pop_front();
        for (int i = 0; i < exp_th_pkg::LANES; i++)
          if (got.lane[i] !== want.lane[i])
            report_mismatch($sformatf("exp_lane%0d", i), 64'(got.lane[i]),
                            64'(want.lane[i]));
        if (got.mask !== want.mask)
          report_mismatch("saturated_mask", 64'(got.mask), 64'(want.mask));
      end
    end
    if (in_valid_i && in_ready_o) begin
      a[0] = x_lane0_i;
      a[1] = x_lane1_i;
      a[2] = x_lane2_i;
      a[3] = x_lane3_i;
      exp_due_q.push_back(predict_exp(a));
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus plan
  initial begin : stimulus
    // term counts per random batch: extremes, out-of-range values, odd
    // small counts where large negative arguments sum below zero
    int unsigned terms_plan [PLAN_LEN] = '{2, 7, 0, 12, 1, 4, 16, 127, 3, 65, 10, 64};
    int unsigned batch;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset term count (64)
    push_item('0, '0, '0, '0);
    push_item(X_MAX, X_MAX, X_MAX, X_MAX);
    push_item(X_MIN, X_MIN, X_MIN, X_MIN);
    push_item(exp_th_pkg::X_W'(1), exp_th_pkg::X_W'(-1),
              exp_th_pkg::X_W'(65536), exp_th_pkg::X_W'(-65536));
    push_item(X_MAX, X_MIN, '0, exp_th_pkg::X_W'(32768));

    // below the floor: behaves as two terms
    set_terms(7'd0);
    push_item(X_MIN, X_MAX, exp_th_pkg::X_W'(-65536), exp_th_pkg::X_W'(65536));
    push_item(exp_th_pkg::X_W'(-131072), exp_th_pkg::X_W'(131072),
              exp_th_pkg::X_W'(1), exp_th_pkg::X_W'(-1));
    set_terms(7'd1);
    push_item(X_MIN, X_MAX, '0, exp_th_pkg::X_W'(-1));

    // three terms: large negative arguments give a negative sum, cleared to 0
    set_terms(7'd3);
    push_item(X_MIN, exp_th_pkg::X_W'(-655360), exp_th_pkg::X_W'(-327680),
              exp_th_pkg::X_W'(-196608));
    push_item(exp_th_pkg::X_W'(-65536), X_MAX, exp_th_pkg::X_W'(-262144), '0);

    // above the ceiling: behaves as MAX_TERMS
    set_terms(7'd127);
    push_item(X_MIN, X_MAX, exp_th_pkg::X_W'(7), exp_th_pkg::X_W'(-7));
    push_item(exp_th_pkg::X_W'(-1), exp_th_pkg::X_W'(1),
              exp_th_pkg::X_W'(983040), exp_th_pkg::X_W'(-983040));
    set_terms(7'd65);
    push_item(X_MAX, X_MIN, exp_th_pkg::X_W'(655360), exp_th_pkg::X_W'(-655360));

    // Random batches, one stall style each; long-series batches kept short
    for (int p = 0; p < PLAN_LEN; p++) begin
      set_terms(exp_th_pkg::TERM_W'(terms_plan[p]));
      idle_mode = idle_mode_e'(p % 4);
      if (p == 4) hold_arm = 1'b1;
      batch = (terms_plan[p] >= exp_th_pkg::MAX_TERMS) ? 40 : 190;
      for (int n = 0; n < batch; n++)
        push_item(pick_arg(), pick_arg(), pick_arg(), pick_arg());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
